// ----- rtl/core/first_fit_extent_allocator_assert.svh -----
// Assertion macros shared by the extent allocator RTL.
// Needs a clock named clk and a synchronous reset named rst in scope.
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_ASSERT_SVH
// Condition holds at every edge out of reset.
`define FFEA_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Antecedent at one edge implies consequent at the next edge.
`define FFEA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- rtl/core/ffea_pkg.sv -----
// Types and codes for the first-fit extent allocator.
// No dependencies; used by every module of the block.
package ffea_pkg;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_DROP  = 2'd2
  } status_t;

  localparam logic [1:0] REG_REGION_START = 2'd0;
  localparam logic [1:0] REG_REGION_BYTES = 2'd1;

  typedef struct packed {
    logic        op;
    logic [31:0] req_size;
    logic [31:0] free_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] grant_address;
    logic [31:0] grant_size;
  } res_t;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] len;
  } ext_t;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] len;
    logic [32:0] key_addr;
    logic [31:0] key_size;
    logic [31:0] sum_a;
    logic [31:0] sum_b;
  } alu_in_t;

  typedef struct packed {
    logic [31:0] gap;
    logic [31:0] avail;
    logic [31:0] tail;
    logic [31:0] aligned;
    logic [31:0] next_base;
    logic        fits;
    logic        above;
    logic        touch_next;
    logic        touch_prev;
    logic [32:0] end_of;
    logic [31:0] sat_sum;
  } alu_out_t;

endpackage

// ----- rtl/core/ffea_table.sv -----
// Extent table memory: one write port, one registered read port.
// Entry zero reads as the region registers until first written after reset or a rebuild.
module ffea_table
  import ffea_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rebuild,
  input  logic [31:0]   init_base,
  input  logic [31:0]   init_len,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  ext_t          wdata,
  input  logic [IW-1:0] raddr,
  output ext_t          rdata
);

  ext_t mem [DEPTH];
  logic init_pending;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (raddr == '0 && init_pending) begin
      rdata <= '{base: init_base, len: init_len};
    end else begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || rebuild) begin
      init_pending <= 1'b1;
    end else if (we && waddr == '0) begin
      init_pending <= 1'b0;
    end
  end

endmodule

// ----- rtl/core/ffea_alu.sv -----
// Shared evaluation unit: alignment gap, fit test, adjacency compares and
// saturating add for one table entry. Uses ffea_pkg.
module ffea_alu
  import ffea_pkg::*;
#(
  parameter int ALIGNMENT = 64
) (
  input  alu_in_t  a,
  output alu_out_t y
);

  localparam logic [31:0] MASK = 32'(ALIGNMENT - 1);

  logic [32:0] sum;

  always_comb begin
    y.gap        = (32'd0 - a.base) & MASK;
    y.avail      = a.len - y.gap;
    y.fits       = (y.gap <= a.len) && (y.avail >= a.key_size);
    y.tail       = y.avail - a.key_size;
    y.aligned    = a.base + y.gap;
    y.next_base  = y.aligned + a.key_size;
    y.above      = {1'b0, a.base} > a.key_addr;
    y.touch_next = (a.key_addr + {1'b0, a.key_size}) == {1'b0, a.base};
    y.end_of     = {1'b0, a.base} + {1'b0, a.len};
    y.touch_prev = y.end_of == a.key_addr;
    sum          = {1'b0, a.sum_a} + {1'b0, a.sum_b};
    y.sat_sum    = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  end

endmodule

// ----- rtl/core/first_fit_extent_allocator.sv -----
// First-fit extent allocator with coalescing on free.
// Uses ffea_pkg, ffea_table, ffea_alu and the assertion macro header.
//
// Usage:
//   Request channel: drive req and pulse start while busy is low; the request
//   is taken at that edge and busy rises at once.
//   Result channel: done is high for exactly one cycle with res valid; the
//   receiver cannot hold it off. busy falls the cycle after done, so one
//   request is in flight at a time.
//   Config port: cfg_we/cfg_index/cfg_data write the region start (index 0)
//   or the region size (index 1) while idle; either rebuilds the table.
// Sequencing: the scan reads and then evaluates each table entry in turn; an
//   insert or a removal shifts entries one at a time with a read and a write
//   state, and a coalescing free checks each neighbor with a read and an
//   evaluate state; done is raised from its own state. An oversized allocate
//   goes from idle straight to that done state. Each absorbed neighbor
//   reshifts the rest of the table, so a free that swallows a run of touching
//   extents pays a full shift for each neighbor. All of it comes from the
//   table's single read and single write port and the one shared unit.
// Reset: the table holds one extent (start, size) = (0, 0) and no request is
//   in flight. No clearing pass is needed.
`include "first_fit_extent_allocator_assert.svh"
module first_fit_extent_allocator
  import ffea_pkg::*;
#(
  parameter int MAX_EXTENTS = 16,
  parameter int ALIGNMENT   = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        req,
  output logic        done,
  output res_t        res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam logic [31:0] MASK  = 32'(ALIGNMENT - 1);
  localparam logic [CW-1:0] CMAX = CW'(MAX_EXTENTS);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_SCAN_RD = 10'b00_0000_0010,
    S_SCAN_EV = 10'b00_0000_0100,
    S_INS_RD  = 10'b00_0000_1000,
    S_INS_WR  = 10'b00_0001_0000,
    S_REM_RD  = 10'b00_0010_0000,
    S_REM_WR  = 10'b00_0100_0000,
    S_MRG_RD  = 10'b00_1000_0000,
    S_MRG_EV  = 10'b01_0000_0000,
    S_DONE    = 10'b10_0000_0000
  } state_t;

  state_t      state;
  logic [CW-1:0] cnt, idx, sp, ins_pos;
  logic        op;
  logic [31:0] rsize, addr, acc_base, acc_len;
  logic [32:0] mend;
  logic        merge_after;
  ext_t        ins_data;
  logic [1:0]  status;
  logic [31:0] gaddr, gsize;

  logic [31:0] region_start, region_bytes;
  logic        rebuild;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  ext_t          wdata, rdata;
  alu_in_t       ai;
  alu_out_t      ao;

  logic [CW-1:0] idx_inc, sp_inc;

  assign idx_inc = idx + CW'(1);
  assign sp_inc  = sp + CW'(1);
  assign rebuild = cfg_we && (cfg_index == REG_REGION_START ||
                              cfg_index == REG_REGION_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      region_start <= '0;
      region_bytes <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_REGION_START) region_start <= cfg_data;
      if (cfg_index == REG_REGION_BYTES) region_bytes <= cfg_data;
    end
  end

  ffea_table #(.DEPTH(MAX_EXTENTS), .IW(IW)) u_table (
    .clk       (clk),
    .rst       (rst),
    .rebuild   (rebuild),
    .init_base (region_start),
    .init_len  (region_bytes),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  ffea_alu #(.ALIGNMENT(ALIGNMENT)) u_alu (
    .a (ai),
    .y (ao)
  );

  // operand select for the shared unit
  always_comb begin
    ai.base = rdata.base;
    ai.len  = rdata.len;
    if (state == S_MRG_EV) begin
      ai.key_addr = mend;
      ai.key_size = '0;
      ai.sum_a    = acc_len;
      ai.sum_b    = rdata.len;
    end else begin
      ai.key_addr = {1'b0, addr};
      ai.key_size = rsize;
      ai.sum_a    = rdata.len;
      ai.sum_b    = rsize;
    end
  end

  // table port control
  always_comb begin
    we    = 1'b0;
    waddr = idx[IW-1:0];
    wdata = ins_data;
    raddr = idx[IW-1:0];
    case (state)
      S_SCAN_EV: begin
        if (op == OP_ALLOC && ao.fits) begin
          we    = 1'b1;
          wdata = (ao.gap == '0) ? ext_t'{base: ao.next_base, len: ao.tail}
                                 : ext_t'{base: rdata.base, len: ao.gap};
        end else if (op == OP_FREE && ao.above && ao.touch_next) begin
          we    = 1'b1;
          wdata = '{base: addr, len: ao.sat_sum};
        end
      end
      S_INS_RD: begin
        raddr = IW'(sp - CW'(1));
        if (sp == ins_pos) begin
          we    = 1'b1;
          waddr = sp[IW-1:0];
        end
      end
      S_INS_WR: begin
        we    = 1'b1;
        waddr = sp[IW-1:0];
        wdata = rdata;
      end
      S_REM_RD: raddr = sp_inc[IW-1:0];
      S_REM_WR: begin
        we    = 1'b1;
        waddr = sp[IW-1:0];
        wdata = rdata;
      end
      S_MRG_RD: begin
        raddr = idx_inc[IW-1:0];
        if (idx_inc >= cnt) begin
          we    = 1'b1;
          wdata = '{base: acc_base, len: acc_len};
        end
      end
      S_MRG_EV: begin
        if (!ao.touch_next) begin
          we    = 1'b1;
          wdata = '{base: acc_base, len: acc_len};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= CW'(1);
    end else begin
      if (rebuild) cnt <= CW'(1);
      case (state)
        S_IDLE: begin
          if (start) begin
            op     <= req.op;
            addr   <= req.free_address;
            idx    <= '0;
            status <= ST_OK;
            gaddr  <= '0;
            gsize  <= '0;
            state  <= S_SCAN_RD;
            if (req.op == OP_ALLOC) begin
              if (req.req_size > ~MASK) begin
                status <= ST_NOFIT;
                state  <= S_DONE;
              end
              rsize <= (req.req_size == '0) ? '0 : ((req.req_size + MASK) & ~MASK);
            end else begin
              rsize <= req.req_size;
            end
          end
        end
        S_SCAN_RD: begin
          if (idx == cnt) begin
            if (op == OP_ALLOC) begin
              status <= ST_NOFIT;
              state  <= S_DONE;
            end else if (cnt == CMAX) begin
              status <= ST_DROP;
              state  <= S_DONE;
            end else begin
              ins_pos  <= cnt;
              ins_data <= '{base: addr, len: rsize};
              sp       <= cnt;
              state    <= S_INS_RD;
            end
          end else begin
            state <= S_SCAN_EV;
          end
        end
        S_SCAN_EV: begin
          if (op == OP_ALLOC) begin
            if (ao.fits) begin
              gaddr <= ao.aligned;
              gsize <= rsize;
              state <= S_DONE;
              if (ao.gap == '0) begin
                if (ao.tail == '0) begin
                  sp          <= idx;
                  merge_after <= 1'b0;
                  state       <= S_REM_RD;
                end
              end else if (ao.tail != '0) begin
                if (cnt != CMAX) begin
                  ins_pos  <= idx_inc;
                  ins_data <= '{base: ao.next_base, len: ao.tail};
                  sp       <= cnt;
                  state    <= S_INS_RD;
                end else begin
                  gsize <= ao.avail;
                end
              end
            end else begin
              idx   <= idx_inc;
              state <= S_SCAN_RD;
            end
          end else begin
            if (ao.above) begin
              if (ao.touch_next) begin
                state <= S_DONE;
              end else if (cnt == CMAX) begin
                status <= ST_DROP;
                state  <= S_DONE;
              end else begin
                ins_pos  <= idx;
                ins_data <= '{base: addr, len: rsize};
                sp       <= cnt;
                state    <= S_INS_RD;
              end
            end else if (ao.touch_prev) begin
              acc_base <= rdata.base;
              acc_len  <= ao.sat_sum;
              mend     <= {1'b0, addr} + {1'b0, rsize};
              state    <= S_MRG_RD;
            end else begin
              idx   <= idx_inc;
              state <= S_SCAN_RD;
            end
          end
        end
        S_INS_RD: begin
          if (sp == ins_pos) begin
            cnt   <= cnt + CW'(1);
            state <= S_DONE;
          end else begin
            state <= S_INS_WR;
          end
        end
        S_INS_WR: begin
          sp    <= sp - CW'(1);
          state <= S_INS_RD;
        end
        S_REM_RD: begin
          if (sp_inc < cnt) begin
            state <= S_REM_WR;
          end else begin
            cnt   <= cnt - CW'(1);
            state <= merge_after ? S_MRG_RD : S_DONE;
          end
        end
        S_REM_WR: begin
          sp    <= sp_inc;
          state <= S_REM_RD;
        end
        S_MRG_RD: begin
          state <= (idx_inc < cnt) ? S_MRG_EV : S_DONE;
        end
        S_MRG_EV: begin
          if (ao.touch_next) begin
            // absorb the touching neighbor, then close the hole it leaves
            acc_len     <= ao.sat_sum;
            mend        <= ao.end_of;
            sp          <= idx_inc;
            merge_after <= 1'b1;
            state       <= S_REM_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);
  assign res  = '{status: status, grant_address: gaddr, grant_size: gsize};

  `FFEA_ASSERT_NOW(a_cnt_bound, cnt <= CMAX, "extent count above table depth")
  `FFEA_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
  `FFEA_ASSERT_NEXT(a_start_busy, start && !busy, busy, "request taken without going busy")
  `FFEA_ASSERT_NOW(a_free_no_grant, !(done && op == OP_FREE) || (gaddr == '0 && gsize == '0),
                   "free request returned a grant")

endmodule

// ----- verif/tb_first_fit_extent_allocator.sv -----
// Testbench for the first-fit extent allocator: directed and random requests,
// checked against a behavioral table model kept inside this module.
// Depends on ffea_pkg and first_fit_extent_allocator.
module tb_first_fit_extent_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import ffea_pkg::*;

  localparam int NEXT = 16;
  localparam int ALIGN = 64;
  localparam logic [32:0] M32 = 33'h0_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic done;
  res_t res;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_REGION_START;
  logic [31:0] cfg_data = '0;

  first_fit_extent_allocator #(.MAX_EXTENTS(NEXT), .ALIGNMENT(ALIGN)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done),
    .res(res), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // model state
  logic [31:0] region_start_m, region_bytes_m;
  logic [31:0] ext_base[NEXT];
  logic [31:0] ext_len[NEXT];
  int ext_cnt;

  req_t pending_reqs[$];
  res_t expected_results[$];
  int errors = 0;
  int sender_idle_pct = 16;
  bit hold_sender = 1'b0;
  bit took = 1'b0;
  int n_alloc = 0, n_free = 0, n_nofit = 0, n_drop = 0;

  function automatic void rebuild_table();
    for (int k = 0; k < NEXT; k++) begin
      ext_base[k] = '0;
      ext_len[k] = '0;
    end
    ext_base[0] = region_start_m;
    ext_len[0] = region_bytes_m;
    ext_cnt = 1;
  endfunction

  function automatic void remove_extent(int i);
    for (int k = i; k < ext_cnt - 1; k++) begin
      ext_base[k] = ext_base[k + 1];
      ext_len[k] = ext_len[k + 1];
    end
    ext_cnt--;
    ext_base[ext_cnt] = '0;
    ext_len[ext_cnt] = '0;
  endfunction

  function automatic void insert_extent(int i, logic [32:0] b, logic [32:0] l);
    for (int k = ext_cnt; k > i; k--) begin
      ext_base[k] = ext_base[k - 1];
      ext_len[k] = ext_len[k - 1];
    end
    ext_base[i] = b[31:0];
    ext_len[i] = l[31:0];
    ext_cnt++;
  endfunction

  function automatic logic [31:0] sat_sum(logic [32:0] a, logic [32:0] b);
    logic [33:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, M32}) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic res_t predict_grant(req_t r);
    res_t o;
    logic [32:0] sz, b, l, gap, avail, addr, tail, fend;
    bit handled;
    o = '0;
    o.status = ST_OK;
    sz = {1'b0, r.req_size};
    handled = 1'b0;
    if (r.op == OP_ALLOC) begin
      o.status = ST_NOFIT;
      if (sz <= M32 - (ALIGN - 1)) begin
        if (sz != 0) sz = (sz + (ALIGN - 1)) & ~33'(ALIGN - 1);
        for (int i = 0; i < ext_cnt; i++) begin
          b = {1'b0, ext_base[i]};
          l = {1'b0, ext_len[i]};
          gap = (ALIGN - (b & (ALIGN - 1))) & (ALIGN - 1);
          if (gap > l) continue;
          avail = l - gap;
          if (avail < sz) continue;
          addr = b + gap;
          o.status = ST_OK;
          o.grant_address = addr[31:0];
          o.grant_size = sz[31:0];
          if (gap == 0) begin
            ext_base[i] = 32'(b + sz);
            ext_len[i] = 32'(l - sz);
            if (ext_len[i] == 0) remove_extent(i);
          end else begin
            tail = avail - sz;
            ext_len[i] = gap[31:0];
            if (tail != 0) begin
              if (ext_cnt < NEXT) insert_extent(i + 1, addr + sz, tail);
              else o.grant_size = 32'(sz + tail);
            end
          end
          break;
        end
      end
    end else begin
      addr = {1'b0, r.free_address};
      for (int i = 0; i < ext_cnt; i++) begin
        b = {1'b0, ext_base[i]};
        if (b > addr) begin
          if (addr + sz == b) begin
            ext_base[i] = addr[31:0];
            ext_len[i] = sat_sum({1'b0, ext_len[i]}, sz);
          end else if (ext_cnt >= NEXT) o.status = ST_DROP;
          else insert_extent(i, addr, sz);
          handled = 1'b1;
          break;
        end
        if (b + ext_len[i] == addr) begin
          fend = addr + sz;
          ext_len[i] = sat_sum({1'b0, ext_len[i]}, sz);
          while (i + 1 < ext_cnt && {1'b0, ext_base[i + 1]} == fend) begin
            fend = fend + ext_len[i + 1];
            ext_len[i] = sat_sum({1'b0, ext_len[i]}, {1'b0, ext_len[i + 1]});
            remove_extent(i + 1);
          end
          handled = 1'b1;
          break;
        end
      end
      if (!handled) begin
        if (ext_cnt >= NEXT) o.status = ST_DROP;
        else insert_extent(ext_cnt, addr, sz);
      end
    end
    if (o.status != ST_OK) begin
      o.grant_address = '0;
      o.grant_size = '0;
    end
    return o;
  endfunction

  // note each request the block takes at the rising edge
  always @(posedge clk) took <= !rst && start && !busy;

  // driver: hold start until the block takes the request
  always @(negedge clk) begin
    if (!rst) begin
      if (took) begin
        expected_results.push_back(predict_grant(req));
        if (req.op == OP_ALLOC) n_alloc++;
        else n_free++;
        void'(pending_reqs.pop_front());
      end
      if (pending_reqs.size() > 0 && !hold_sender && (took || !start) &&
          $urandom_range(99) >= sender_idle_pct) begin
        start <= 1'b1;
        req <= pending_reqs[0];
      end else if (took) begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result status=%0d", res.status);
        errors++;
      end else begin
        res_t e;
        e = expected_results.pop_front();
        if (res.status == ST_NOFIT) n_nofit++;
        if (res.status == ST_DROP) n_drop++;
        if (res.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, res.status);
          errors++;
        end
        if (res.grant_address !== e.grant_address) begin
          $error("grant_address: expected %h, got %h", e.grant_address, res.grant_address);
          errors++;
        end
        if (res.grant_size !== e.grant_size) begin
          $error("grant_size: expected %h, got %h", e.grant_size, res.grant_size);
          errors++;
        end
      end
    end
  end

  task automatic add_request(op_t op, logic [31:0] sz, logic [31:0] ad);
    req_t r;
    r.op = op;
    r.req_size = sz;
    r.free_address = ad;
    pending_reqs.push_back(r);
  endtask

  task automatic drain_all();
    while (pending_reqs.size() > 0 || start || busy || expected_results.size() > 0)
      @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_REGION_START) region_start_m = val;
    else if (idx == REG_REGION_BYTES) region_bytes_m = val;
    rebuild_table();
  endtask

  // random traffic: allocates, frees at addresses from the region base, and fully random requests
  task automatic add_random_traffic(int n, logic [31:0] pb, logic [31:0] span);
    for (int k = 0; k < n; k++) begin
      int pick;
      logic [31:0] sz, ad;
      pick = $urandom_range(99);
      case (1'b1)
        pick < 45: begin
          sz = ($urandom_range(3) == 0) ? $urandom : $urandom_range(span / 8);
          add_request(OP_ALLOC, sz, $urandom);
        end
        pick < 85: begin
          ad = pb + ($urandom_range(span / ALIGN) * ALIGN);
          sz = $urandom_range(8) * ALIGN;
          if ($urandom_range(4) == 0) sz = $urandom_range(span / 4);
          add_request(OP_FREE, sz, ad);
        end
        default: add_request(op_t'($urandom_range(1)), $urandom, $urandom);
      endcase
    end
  endtask

  initial begin
    region_start_m = '0;
    region_bytes_m = '0;
    rebuild_table();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty pool after reset
    add_request(OP_ALLOC, 32'd0, 32'd0);
    add_request(OP_ALLOC, 32'd1, 32'd0);
    drain_all();

    write_reg(REG_REGION_START, 32'h0000_1000);
    write_reg(REG_REGION_BYTES, 32'h0001_0000);
    write_reg(2'd3, 32'hDEAD_BEEF);
    add_request(OP_ALLOC, 32'hFFFF_FFC1, 32'd0);
    add_request(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
    add_request(OP_ALLOC, 32'd0, 32'd0);
    add_request(OP_ALLOC, 32'd1, 32'd0);
    add_request(OP_ALLOC, 32'd64, 32'd0);
    add_request(OP_FREE, 32'd64, 32'h0000_1000);
    add_request(OP_FREE, 32'd0, 32'h0000_0100);
    add_request(OP_FREE, 32'd64, 32'h0000_1040);
    add_request(OP_ALLOC, 32'h0001_0000, 32'd0);
    for (int k = 0; k < 17; k++) add_request(OP_FREE, 32'd16, 32'h0010_0000 + k * 64);
    drain_all();

    // misaligned base: the gap splits off, then frees near the ends of the address space and a huge allocate
    write_reg(REG_REGION_START, 32'hFFFF_FF05);
    write_reg(REG_REGION_BYTES, 32'hFFFF_FFFF);
    add_request(OP_ALLOC, 32'd100, 32'd0);
    add_request(OP_FREE, 32'hFFFF_FFFF, 32'h0000_0000);
    add_request(OP_FREE, 32'h10, 32'hFFFF_FFF0);
    add_request(OP_ALLOC, 32'hFFFF_FFC0, 32'd0);
    drain_all();

    for (int ph = 0; ph < 3; ph++) begin
      logic [31:0] pb, ps;
      sender_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 57 : 0;
      pb = $urandom & ~32'(ALIGN - 1);
      if (ph == 1) pb = pb | 32'h11;
      ps = (ph == 2) ? 32'hFFFF_FFFF : $urandom_range(32'h4000, 32'h8000);
      write_reg(REG_REGION_START, pb);
      write_reg(REG_REGION_BYTES, ps);
      add_random_traffic(200, pb, ps);
      // hold off until every result is back, then resume
      while (pending_reqs.size() > 0) @(negedge clk);
      hold_sender = 1'b1;
      while (busy || start || expected_results.size() > 0) @(negedge clk);
      hold_sender = 1'b0;
      add_random_traffic(200, pb, ps);
      drain_all();
    end

    $display("covered %0d allocates and %0d frees; %0d no-fit and %0d dropped results",
             n_alloc, n_free, n_nofit, n_drop);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end
endmodule
